/* hw/rtl/tfmc_pkg.sv */
// Package for the thermostat fan mode controller.
// Holds the mode type, keypad and fan drive codes, and register indexes.
// It depends on nothing else.
package tfmc_pkg;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_SLEEP  = 2'd2
  } mode_t;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int TARGET_W    = 5;
  localparam int TEMP_W      = 8;
  localparam int IDLE_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_TARGET = 2'd1;

  localparam logic [7:0] KEY_UP    = 8'h19;
  localparam logic [7:0] KEY_DOWN  = 8'h11;
  localparam logic [7:0] KEY_POWER = 8'h01;

  localparam logic [TARGET_W-1:0] TARGET_MIN   = 5'd16;
  localparam logic [TARGET_W-1:0] TARGET_MAX   = 5'd30;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 5'd26;

  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 16'd50000;
  localparam logic [TEMP_W-1:0] TEMP_RESET       = 8'd1;

  localparam logic [7:0] CMD_STOP = 8'h00;
  localparam logic [7:0] CMD_L1   = 8'h0A;
  localparam logic [7:0] CMD_L2   = 8'h05;
  localparam logic [7:0] CMD_L3   = 8'h03;

  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_SHORT = 2'd1;
  localparam logic [1:0] BEEP_LONG  = 2'd2;

  function automatic logic [7:0] level_cmd(input logic [1:0] level);
    logic [7:0] cmd;
    unique case (level)
      2'd0:    cmd = CMD_STOP;
      2'd1:    cmd = CMD_L1;
      2'd2:    cmd = CMD_L2;
      default: cmd = CMD_L3;
    endcase
    return cmd;
  endfunction

  function automatic logic [TARGET_W-1:0] clamp_target(input logic [TARGET_W-1:0] v);
    logic [TARGET_W-1:0] r;
    if (v < TARGET_MIN) begin
      r = TARGET_MIN;
    end else if (v > TARGET_MAX) begin
      r = TARGET_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/thermostat_fan_mode_controller.sv */
// Thermostat fan mode controller: mode rules, target keys and fan level choice.
// Uses tfmc_pkg for the mode type, codes and register indexes.
// The result of each accepted item is registered in the output register.
// Throughput: one item per cycle while the output is not stalled; all state updates in the accepting cycle.
// An item is taken whenever the output register is empty or is being emptied.
// Reset (synchronous, active high): mode off, target 26, idle count 0,
// fan level 0, stored temperature 1, idle limit 50000, output register empty.
module thermostat_fan_mode_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic                              key_valid,
  input  logic [7:0]                        key_code,
  input  logic                              temp_valid,
  input  logic signed [tfmc_pkg::TEMP_W-1:0] measured_temp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        mode,
  output logic [tfmc_pkg::TARGET_W-1:0]     target_temp,
  output logic [1:0]                        fan_level,
  output logic                              fan_write,
  output logic [7:0]                        fan_command,
  output logic [2:0]                        indicator,
  output logic [1:0]                        beep,
  output logic                              display_on,
  input  logic                              cfg_write,
  input  logic [tfmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tfmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tfmc_pkg::mode_t                    mode_reg, mode_next;
  logic [tfmc_pkg::TARGET_W-1:0]      target_reg, target_next;
  logic [tfmc_pkg::IDLE_W-1:0]        idle_count, idle_count_next, idle_after_key;
  logic [1:0]                         level_reg, level_next;
  logic signed [tfmc_pkg::TEMP_W-1:0] temp_reg, temp_next;
  logic [tfmc_pkg::IDLE_W-1:0]        idle_limit;

  logic       accept;
  logic       is_pass;
  logic       key_up, key_down, key_power;
  logic       unit_on;
  logic       power_off;
  logic [1:0] want;
  logic signed [9:0] diff;
  logic       write_next;
  logic [7:0] cmd_next;
  logic [1:0] beep_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_pass  = action;

  assign key_up    = key_valid && (key_code == tfmc_pkg::KEY_UP);
  assign key_down  = key_valid && (key_code == tfmc_pkg::KEY_DOWN);
  assign key_power = key_valid && (key_code == tfmc_pkg::KEY_POWER);
  assign unit_on   = (mode_reg != tfmc_pkg::MODE_OFF);

  // A new sample is stored on a pass only; ticks ignore it.
  assign temp_next = (is_pass && temp_valid) ? measured_temp : temp_reg;

  always_comb begin
    target_next = target_reg;
    if (is_pass && unit_on) begin
      if (key_up && target_reg < tfmc_pkg::TARGET_MAX) begin
        target_next = target_reg + 5'd1;
      end else if (key_down && target_reg > tfmc_pkg::TARGET_MIN) begin
        target_next = target_reg - 5'd1;
      end
    end
  end

  assign idle_after_key = (key_valid && mode_reg == tfmc_pkg::MODE_NORMAL) ?
                          '0 : idle_count;

  // Next mode and idle count. Power beats both timeout and wake-up.
  always_comb begin
    mode_next       = mode_reg;
    idle_count_next = idle_count;
    power_off       = 1'b0;
    if (!is_pass) begin
      if (mode_reg == tfmc_pkg::MODE_NORMAL && idle_count < idle_limit) begin
        idle_count_next = idle_count + 16'd1;
      end
    end else begin
      idle_count_next = idle_after_key;
      unique case (mode_reg)
        tfmc_pkg::MODE_NORMAL: begin
          if (key_power) begin
            mode_next = tfmc_pkg::MODE_OFF;
            power_off = 1'b1;
          end else if (idle_after_key >= idle_limit) begin
            idle_count_next = '0;
            mode_next       = tfmc_pkg::MODE_SLEEP;
          end
        end
        tfmc_pkg::MODE_SLEEP: begin
          if (key_power) begin
            mode_next = tfmc_pkg::MODE_OFF;
            power_off = 1'b1;
          end else if (key_valid) begin
            mode_next = tfmc_pkg::MODE_NORMAL;
          end
        end
        default: begin
          if (key_power) begin
            mode_next = tfmc_pkg::MODE_NORMAL;
          end
        end
      endcase
    end
  end

  assign diff = 10'(temp_next) - $signed({5'b0, target_next});

  always_comb begin
    if (diff <= 10'sd0) begin
      want = 2'd0;
    end else if (diff < 10'sd2) begin
      want = 2'd1;
    end else if (diff < 10'sd4) begin
      want = 2'd2;
    end else begin
      want = 2'd3;
    end
  end

  // Fan level, drive command and beep.
  always_comb begin
    level_next = level_reg;
    write_next = 1'b0;
    cmd_next   = tfmc_pkg::CMD_STOP;
    beep_next  = tfmc_pkg::BEEP_NONE;
    if (is_pass) begin
      if (key_valid && unit_on) begin
        beep_next = tfmc_pkg::BEEP_SHORT;
      end
      if (!unit_on && key_power) begin
        beep_next = tfmc_pkg::BEEP_LONG;
      end
      if (power_off) begin
        if (level_reg != 2'd0) begin
          write_next = 1'b1;
          level_next = 2'd0;
        end
      end else if (mode_next != tfmc_pkg::MODE_OFF && want != level_reg) begin
        write_next = 1'b1;
        cmd_next   = tfmc_pkg::level_cmd(want);
        level_next = want;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= tfmc_pkg::MODE_OFF;
      target_reg <= tfmc_pkg::TARGET_RESET;
      idle_count <= '0;
      level_reg  <= 2'd0;
      temp_reg   <= tfmc_pkg::TEMP_RESET;
      idle_limit <= tfmc_pkg::IDLE_LIMIT_RESET;
    end else if (accept) begin
      mode_reg   <= mode_next;
      target_reg <= target_next;
      idle_count <= idle_count_next;
      level_reg  <= level_next;
      temp_reg   <= temp_next;
    end else if (cfg_write) begin
      if (cfg_index == tfmc_pkg::REG_IDLE_LIMIT) begin
        idle_limit <= cfg_data;
      end else if (cfg_index == tfmc_pkg::REG_INIT_TARGET) begin
        target_reg <= tfmc_pkg::clamp_target(cfg_data[tfmc_pkg::TARGET_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode        <= 2'(mode_next);
      target_temp <= target_next;
      fan_level   <= level_next;
      fan_write   <= write_next;
      fan_command <= cmd_next;
      indicator   <= (mode_next == tfmc_pkg::MODE_NORMAL) ?
                     ({1'b0, level_next} + 3'd1) : 3'd0;
      beep        <= beep_next;
      display_on  <= (mode_next == tfmc_pkg::MODE_NORMAL);
    end
  end

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    target_reg >= tfmc_pkg::TARGET_MIN && target_reg <= tfmc_pkg::TARGET_MAX)
    else $error("target register left its range");

  a_off_no_fan: assert property (@(posedge clk) disable iff (rst)
    mode_reg == tfmc_pkg::MODE_OFF |-> level_reg == 2'd0)
    else $error("fan level nonzero while off");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_cmd_only_on_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fan_write |-> fan_command == tfmc_pkg::CMD_STOP)
    else $error("fan command without write");

  a_display_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_on |-> indicator != 3'd0)
    else $error("display on with no lamp lit");

endmodule
